// File: rtl/core/vdma_pkg.sv
// Shared types and constants for the missing-aware vector distance block.
// No dependencies; every other file in rtl/core refers to it by scoped names.
`timescale 1ns / 1ps

package vdma_pkg;

	localparam int MAX_LENGTH = 256;
	localparam int CNT_W      = $clog2(MAX_LENGTH + 1);
	localparam int VAL_W      = 16;
	localparam int SUM_W      = 48;
	localparam int DIV_W      = 64;
	localparam int SQRT_STEPS = 32;
	localparam int ITER_W     = 6;
	localparam int FRAC_W     = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;

	localparam logic signed [VAL_W-1:0] HALF_Q88 = 16'sd128;

	localparam logic [1:0] METRIC_EUCLID   = 2'd0;
	localparam logic [1:0] METRIC_SUMSQ    = 2'd1;
	localparam logic [1:0] METRIC_MANHATAN = 2'd2;
	localparam logic [1:0] METRIC_TANIMOTO = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_METRIC        = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MISSING_AWARE = 8'd1;

	typedef struct packed {
		logic acc;
		logic prep;
		logic div_step;
		logic post;
		logic sqrt_step;
		logic load_out;
	} vdma_cmd_t;

	typedef struct packed {
		logic k_zero;
		logic euclid;
	} vdma_stat_t;

endpackage

// File: rtl/core/vdma_if.sv
// Channel interfaces for element input, result output and register writes.
// Depends on vdma_pkg for field widths.
`timescale 1ns / 1ps

interface vdma_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [vdma_pkg::VAL_W-1:0]  data_value;
	logic signed [vdma_pkg::VAL_W-1:0]  code_value;
	logic                               data_missing;
	logic                               last_element;
	modport source (output valid, data_value, code_value, data_missing, last_element,
		input ready);
	modport sink (input valid, data_value, code_value, data_missing, last_element,
		output ready);
endinterface

interface vdma_out_if;
	logic                        valid;
	logic                        ready;
	logic [vdma_pkg::SUM_W-1:0]  distance;
	logic                        not_available;
	modport source (output valid, distance, not_available, input ready);
	modport sink (input valid, distance, not_available, output ready);
endinterface

interface vdma_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [vdma_pkg::CFG_IDX_W-1:0]   index;
	logic [vdma_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/vdma_dp.sv
// Datapath: accumulator, shared radix-2 divider and bit-serial square root.
// Depends on vdma_pkg; driven by vdma_ctrl through vdma_cmd_t.
`timescale 1ns / 1ps

module vdma_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  vdma_pkg::vdma_cmd_t                cmd,
	output vdma_pkg::vdma_stat_t               stat,
	input  logic signed [vdma_pkg::VAL_W-1:0]  data_value,
	input  logic signed [vdma_pkg::VAL_W-1:0]  code_value,
	input  logic                               data_missing,
	input  logic [1:0]                         metric,
	input  logic                               missing_aware,
	output logic [vdma_pkg::SUM_W-1:0]         distance,
	output logic                               not_available
);

	localparam int CW = vdma_pkg::CNT_W;
	localparam int SW = vdma_pkg::SUM_W;
	localparam int DW = vdma_pkg::DIV_W;
	localparam int VAL_W_EXT = vdma_pkg::VAL_W + 1;

	logic [CW-1:0] elem_cnt_q, miss_cnt_q, k_q;
	logic [SW-1:0] sum_q, res_q, dist_q;
	logic [DW-1:0] work_q, quot_q, bit_q;
	logic [CW:0]   rem_q;
	logic          euc_q, kz_q, tani_q, na_q;

	logic signed [VAL_W_EXT-1:0] diff;
	logic [vdma_pkg::VAL_W-1:0]   mag;
	logic [2*vdma_pkg::VAL_W-1:0] sq, add;
	logic [SW:0]                  sum_ext;
	logic                         mismatch, take;
	logic [CW-1:0]                k_now;
	logic [SW+CW-1:0]             prod;
	logic [DW-1:0]                dividend;
	logic [CW:0]                  rem_sh;
	logic                         q_bit;
	logic [SW-1:0]                s_val;
	logic [DW-1:0]                trial;

	always_comb begin
		diff     = VAL_W_EXT'(data_value) - VAL_W_EXT'(code_value);
		mag      = diff[VAL_W_EXT-1] ? vdma_pkg::VAL_W'(-diff) : diff[vdma_pkg::VAL_W-1:0];
		sq       = mag * mag;
		mismatch = (data_value > vdma_pkg::HALF_Q88 && code_value < vdma_pkg::HALF_Q88) ||
			(data_value <= vdma_pkg::HALF_Q88 && code_value >= vdma_pkg::HALF_Q88);
		unique case (metric)
			vdma_pkg::METRIC_EUCLID, vdma_pkg::METRIC_SUMSQ: add = sq;
			vdma_pkg::METRIC_MANHATAN: add = {8'd0, mag, 8'd0};
			default: add = {31'd0, mismatch};
		endcase
		sum_ext  = {1'b0, sum_q} + {(SW + 1 - 2 * vdma_pkg::VAL_W)'(0), add};
		take     = elem_cnt_q < CW'(vdma_pkg::MAX_LENGTH);
		k_now    = missing_aware ? elem_cnt_q - miss_cnt_q : elem_cnt_q;
		prod     = sum_q * elem_cnt_q;
		// tanimoto divides the sum shifted left by 16 bits; the rescale needs the product
		dividend = (metric == vdma_pkg::METRIC_TANIMOTO) ? {sum_q, 16'd0}
			: DW'(prod);
		rem_sh   = {rem_q[CW-1:0], work_q[DW-1]};
		q_bit    = rem_sh >= {1'b0, k_q};
		s_val    = tani_q ? quot_q[SW-1:0]
			: ((|quot_q[DW-1:SW]) ? {SW{1'b1}} : quot_q[SW-1:0]);
		trial    = quot_q + bit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_cnt_q <= '0;
			miss_cnt_q <= '0;
			sum_q      <= '0;
		end else if (cmd.prep) begin
			elem_cnt_q <= '0;
			miss_cnt_q <= '0;
			sum_q      <= '0;
		end else if (cmd.acc && take) begin
			elem_cnt_q <= elem_cnt_q + CW'(1);
			if (data_missing) begin
				miss_cnt_q <= miss_cnt_q + CW'(1);
			end
			if (!(missing_aware && data_missing)) begin
				sum_q <= sum_ext[SW] ? {SW{1'b1}} : sum_ext[SW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			k_q    <= k_now;
			work_q <= dividend;
			quot_q <= '0;
			rem_q  <= '0;
			res_q  <= '0;
			euc_q  <= metric == vdma_pkg::METRIC_EUCLID;
			tani_q <= metric == vdma_pkg::METRIC_TANIMOTO;
			kz_q   <= k_now == '0;
		end else if (cmd.div_step) begin
			rem_q  <= q_bit ? rem_sh - {1'b0, k_q} : rem_sh;
			work_q <= {work_q[DW-2:0], 1'b0};
			quot_q <= {quot_q[DW-2:0], q_bit};
		end else if (cmd.post) begin
			res_q  <= s_val;
			work_q <= {s_val, 16'd0};
			quot_q <= '0;
			bit_q  <= DW'(1) << (DW - 2);
		end else if (cmd.sqrt_step) begin
			if (work_q >= trial) begin
				work_q <= work_q - trial;
				quot_q <= (quot_q >> 1) + bit_q;
			end else begin
				quot_q <= quot_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.load_out) begin
			dist_q <= (euc_q && !kz_q) ? quot_q[SW-1:0] : res_q;
			na_q   <= kz_q;
		end
	end

	assign stat.k_zero   = kz_q;
	assign stat.euclid   = euc_q;
	assign distance      = dist_q;
	assign not_available = na_q;

endmodule

// File: rtl/core/vdma_ctrl.sv
// Controller: sequences accumulate, divide, square root and result hand-off.
// Depends on vdma_pkg; commands vdma_dp.
`timescale 1ns / 1ps

module vdma_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_last,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output vdma_pkg::vdma_cmd_t   cmd,
	input  vdma_pkg::vdma_stat_t  stat
);

	localparam logic [2:0] ST_ACC  = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_POST = 3'd3;
	localparam logic [2:0] ST_SQRT = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	localparam logic [vdma_pkg::ITER_W-1:0] DIV_LAST  = '1;
	localparam logic [vdma_pkg::ITER_W-1:0] SQRT_LAST =
		vdma_pkg::ITER_W'(vdma_pkg::SQRT_STEPS - 1);

	logic [2:0]                  state_q;
	logic [vdma_pkg::ITER_W-1:0] iter_q;
	logic                        out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.acc       = (state_q == ST_ACC) && in_valid;
		cmd.prep      = state_q == ST_PREP;
		cmd.div_step  = (state_q == ST_DIV) && !stat.k_zero;
		cmd.post      = state_q == ST_POST;
		cmd.sqrt_step = state_q == ST_SQRT;
		cmd.load_out  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	assign in_ready  = state_q == ST_ACC;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_ACC: begin
					if (in_valid && in_last) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					iter_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					iter_q <= iter_q + vdma_pkg::ITER_W'(1);
					if (stat.k_zero) begin
						state_q <= ST_DONE;
					end else if (iter_q == DIV_LAST) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					iter_q  <= '0;
					state_q <= stat.euclid ? ST_SQRT : ST_DONE;
				end
				ST_SQRT: begin
					iter_q <= iter_q + vdma_pkg::ITER_W'(1);
					if (iter_q == SQRT_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (cmd.load_out) begin
						state_q <= ST_ACC;
					end
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

endmodule

// File: rtl/core/vector_distance_missing_aware.sv
// Top level of the missing-aware vector distance block: register file and wiring.
// Depends on vdma_pkg, vdma_if, vdma_ctrl and vdma_dp.
//
// Element pairs stream in at one transaction per clock while a vector is open;
// the transaction that carries last_element closes it, and the block then
// stops taking elements while one shared unit works out the result: a set-up
// step, a radix-2 divide (the n/(n-missing) rescale, or the mismatch count
// over k for tanimoto), a step that saturates the quotient (tanimoto only
// truncates it), for euclidean a square root, and a hand-off step; when every
// element is missing in missing-aware mode the result (not_available) skips
// the divide. The result shows on the output in the cycle after the hand-off.
// The result sits in an output register, so the next vector may start
// streaming while it waits to be taken; a further result waits in the
// controller until that register frees, which stalls that vector. Register
// writes (index 0 metric, index 1 missing_aware) are always accepted and
// should only happen while no vector is open or result is pending.
`timescale 1ns / 1ps

module vector_distance_missing_aware (
	input  logic       clk,
	input  logic       arst_n,
	vdma_in_if.sink    in_ch,
	vdma_out_if.source out_ch,
	vdma_cfg_if.sink   cfg_ch
);

	logic [1:0]            metric_q;
	logic                  aware_q;
	vdma_pkg::vdma_cmd_t   cmd;
	vdma_pkg::vdma_stat_t  stat;

	// Register writes are always taken and land in the next cycle; unknown indexes drop silently.
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q <= vdma_pkg::METRIC_EUCLID;
			aware_q  <= 1'b0;
		end else if (cfg_ch.valid) begin
			if (cfg_ch.index == vdma_pkg::REG_METRIC) begin
				metric_q <= cfg_ch.data[1:0];
			end else if (cfg_ch.index == vdma_pkg::REG_MISSING_AWARE) begin
				aware_q <= cfg_ch.data[0];
			end
		end
	end

	vdma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_last   (in_ch.last_element),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	vdma_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.data_value    (in_ch.data_value),
		.code_value    (in_ch.code_value),
		.data_missing  (in_ch.data_missing),
		.metric        (metric_q),
		.missing_aware (aware_q),
		.distance      (out_ch.distance),
		.not_available (out_ch.not_available)
	);

endmodule

// File: rtl/core/vdma_checker.sv
// Port-level checks for vector_distance_missing_aware, attached with bind.
// Depends on vdma_pkg for widths.
`timescale 1ns / 1ps

module vdma_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        in_last,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [vdma_pkg::SUM_W-1:0]  distance,
	input logic                        not_available
);

	// Hold a result until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance))
		else $error("result dropped or changed while stalled");

	// Stop taking elements once a vector closes.
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("element taken right after vector end");

	// A not-available result carries zero distance.
	a_na_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && not_available |-> distance == '0)
		else $error("not_available with nonzero distance");

	// A new result goes out as the block reopens for elements.
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result issued while elements blocked");

endmodule

bind vector_distance_missing_aware vdma_checker u_vdma_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.in_last       (in_ch.last_element),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.distance      (out_ch.distance),
	.not_available (out_ch.not_available)
);
